/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PWG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pwg assertion failed");

// Checked on every clock edge, reset included.
`define PWG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pwg assertion failed");

`endif

/* hdl/pwg_pkg.sv */
package pwg_pkg;

  localparam int ROM_DEPTH = 100;
  localparam int ROM_AW = 7;
  localparam int DIV_UW = 27;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAWTOOTH = 2'd3
  } shape_t;

  localparam logic [1:0] REG_WAVE_SHAPE      = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE       = 2'd1;
  localparam logic [1:0] REG_MEAN_OFFSET     = 2'd2;
  localparam logic [1:0] REG_TICKS_PER_POINT = 2'd3;

  typedef struct packed {
    shape_t             wave_shape;
    logic        [15:0] amplitude;
    logic signed [15:0] mean_offset;
  } cfg_t;

  function automatic logic [15:0] quarter_wave(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd2057;
      5'd2:    v = 16'd4107;
      5'd3:    v = 16'd6140;
      5'd4:    v = 16'd8149;
      5'd5:    v = 16'd10126;
      5'd6:    v = 16'd12062;
      5'd7:    v = 16'd13952;
      5'd8:    v = 16'd15786;
      5'd9:    v = 16'd17557;
      5'd10:   v = 16'd19260;
      5'd11:   v = 16'd20886;
      5'd12:   v = 16'd22431;
      5'd13:   v = 16'd23886;
      5'd14:   v = 16'd25247;
      5'd15:   v = 16'd26509;
      5'd16:   v = 16'd27666;
      5'd17:   v = 16'd28714;
      5'd18:   v = 16'd29648;
      5'd19:   v = 16'd30466;
      5'd20:   v = 16'd31163;
      5'd21:   v = 16'd31738;
      5'd22:   v = 16'd32187;
      5'd23:   v = 16'd32509;
      5'd24:   v = 16'd32702;
      5'd25:   v = 16'd32767;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // One period of a sine in signed Q1.15, built from the first quarter.
  function automatic logic signed [15:0] sine_value(input logic [ROM_AW-1:0] addr);
    logic [ROM_AW-1:0] k;
    logic [15:0]       mag;
    logic              neg;
    if (addr <= 7'd25) begin
      k = addr;
    end else if (addr <= 7'd50) begin
      k = 7'd50 - addr;
    end else if (addr <= 7'd75) begin
      k = addr - 7'd50;
    end else begin
      k = 7'd100 - addr;
    end
    neg = (addr > 7'd50);
    mag = quarter_wave(k[4:0]);
    return neg ? signed'(16'(-mag)) : signed'(mag);
  endfunction

endpackage

/* hdl/pwg_sequencer.sv */
module pwg_sequencer import pwg_pkg::*; #(
  parameter int POINTS = 100
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      restart,
  input  logic [31:0]               ticks_per_point,
  input  logic                      req_ready,
  output logic                      req_valid,
  output logic [$clog2(POINTS)-1:0] req_index,
  output logic [ROM_AW-1:0]         req_rom_addr
);

  localparam int IW = $clog2(POINTS);
  localparam int Q_INC = ROM_DEPTH / POINTS;
  localparam int R_INC = ROM_DEPTH % POINTS;

  logic [31:0]       tick_count;
  logic [IW-1:0]     point_count;
  logic [ROM_AW-1:0] rom_addr;
  logic [IW-1:0]     rom_rem;

  logic [31:0]       tick_base;
  logic [IW-1:0]     point_base;
  logic [ROM_AW-1:0] addr_base;
  logic [IW-1:0]     rem_base;
  logic [31:0]       period_m1;
  logic              emit;
  logic              accept;
  logic [IW:0]       rem_sum;

  logic [31:0]       tick_count_next;
  logic [IW-1:0]     point_count_next;
  logic [ROM_AW-1:0] rom_addr_next;
  logic [IW-1:0]     rom_rem_next;

  always_comb begin
    tick_base  = restart ? '0 : tick_count;
    point_base = restart ? '0 : point_count;
    addr_base  = restart ? '0 : rom_addr;
    rem_base   = restart ? '0 : rom_rem;
    period_m1  = (ticks_per_point == 32'd0) ? 32'd0 : ticks_per_point - 32'd1;
    emit       = (tick_base >= period_m1);
    accept     = in_valid && req_ready;
    rem_sum    = {1'b0, rem_base} + (IW+1)'(R_INC);

    tick_count_next  = tick_base + 32'd1;
    point_count_next = point_base;
    rom_addr_next    = addr_base;
    rom_rem_next     = rem_base;
    if (emit) begin
      tick_count_next = '0;
      if (point_base == IW'(POINTS - 1)) begin
        point_count_next = '0;
        rom_addr_next    = '0;
        rom_rem_next     = '0;
      end else begin
        point_count_next = point_base + IW'(1);
        if (rem_sum >= (IW+1)'(POINTS)) begin
          rom_addr_next = addr_base + ROM_AW'(Q_INC + 1);
          rom_rem_next  = IW'(rem_sum - (IW+1)'(POINTS));
        end else begin
          rom_addr_next = addr_base + ROM_AW'(Q_INC);
          rom_rem_next  = rem_sum[IW-1:0];
        end
      end
    end
  end

  assign req_valid    = in_valid && emit;
  assign req_index    = point_base;
  assign req_rom_addr = addr_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      point_count <= '0;
      rom_addr    <= '0;
      rom_rem     <= '0;
    end else if (accept) begin
      tick_count  <= tick_count_next;
      point_count <= point_count_next;
      rom_addr    <= rom_addr_next;
      rom_rem     <= rom_rem_next;
    end
  end

endmodule

/* hdl/pwg_shaper.sv */
module pwg_shaper import pwg_pkg::*; #(
  parameter int POINTS = 100
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      req_valid,
  input  logic [$clog2(POINTS)-1:0] req_index,
  input  logic [ROM_AW-1:0]         req_rom_addr,
  output logic                      req_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [15:0]               sample,
  output logic [6:0]                point_index,
  output logic                      clipped
);

  localparam int IW = $clog2(POINTS);
  localparam int P2 = POINTS / 2;
  localparam int P4 = POINTS / 4;
  localparam int UW = DIV_UW;
  localparam int OFF = (1 << 25) / POINTS + 1;
  localparam int OFFP = OFF * POINTS;
  localparam int DSH = UW + $clog2(POINTS);
  localparam int QW = 2 * UW + 1 - DSH;
  localparam int CENTRE = 32768;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DSH) + 64'(POINTS) - 64'd1) / 64'(POINTS);
  localparam logic [UW:0] RECIP = RECIP_FULL[UW:0];

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  logic [IW-1:0]        i1, i2, i3, i4;
  logic signed [16:0]   f1;
  logic signed [33:0]   x2;
  logic signed [17:0]   yq3, yq4;
  logic [UW-1:0]        u3;
  logic                 div3, div4;
  logic [QW-1:0]        qd4;

  logic [IW:0]          idx2;
  logic signed [11:0]   ix;
  logic signed [11:0]   d;
  logic signed [16:0]   f_next;
  logic signed [33:0]   ysh;
  logic signed [27:0]   usum;
  logic                 div_next;
  logic [2*UW:0]        prod;
  logic signed [27:0]   qv;
  logic signed [27:0]   total;

  assign rdy_out   = !out_valid || !out_stall;
  assign rdy4      = !v4 || rdy_out;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req_ready = rdy1;

  always_comb begin
    idx2 = {req_index, 1'b0};
    ix   = signed'(12'(req_index));
    if (ix <= 12'(P2)) begin
      d = 12'(P4) - ix;
    end else begin
      d = ix + 12'(P4) - 12'(2 * P2);
    end
    case (cfg.wave_shape)
      SHAPE_SINE:     f_next = 17'(sine_value(req_rom_addr));
      SHAPE_SQUARE:   f_next = (idx2 < (IW+1)'(POINTS)) ? 17'sd1 : -17'sd1;
      SHAPE_TRIANGLE: f_next = 17'(d);
      SHAPE_SAWTOOTH: f_next = 17'(ix - 12'(P2));
      default:        f_next = '0;
    endcase
  end

  always_comb begin
    case (cfg.wave_shape)
      SHAPE_SINE:     ysh = x2 >>> 17;
      SHAPE_SQUARE:   ysh = x2 >>> 2;
      SHAPE_TRIANGLE: ysh = x2;
      SHAPE_SAWTOOTH: ysh = x2 >>> 1;
      default:        ysh = '0;
    endcase
    div_next = (cfg.wave_shape == SHAPE_TRIANGLE) || (cfg.wave_shape == SHAPE_SAWTOOTH);
    usum     = 28'(signed'(ysh[25:0])) + 28'(OFFP);
  end

  assign prod = (2*UW+1)'(u3) * (2*UW+1)'(RECIP);

  always_comb begin
    qv    = div4 ? signed'(28'(qd4)) - 28'(OFF) : 28'(yq4);
    total = 28'(CENTRE) + 28'(cfg.mean_offset) + qv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= req_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy_out) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && req_valid) begin
      i1 <= req_index;
      f1 <= f_next;
    end
    if (rdy2 && v1) begin
      i2 <= i1;
      x2 <= signed'({1'b0, cfg.amplitude}) * f1;
    end
    if (rdy3 && v2) begin
      i3   <= i2;
      yq3  <= ysh[17:0];
      u3   <= usum[UW-1:0];
      div3 <= div_next;
    end
    if (rdy4 && v3) begin
      i4   <= i3;
      yq4  <= yq3;
      qd4  <= prod[2*UW:DSH];
      div4 <= div3;
    end
    if (rdy_out && v4) begin
      point_index <= 7'({{7{1'b0}}, i4});
      if (total < 28'sd0) begin
        sample  <= 16'h0000;
        clipped <= 1'b1;
      end else if (total > 28'sd65535) begin
        sample  <= 16'hFFFF;
        clipped <= 1'b1;
      end else begin
        sample  <= total[15:0];
        clipped <= 1'b0;
      end
    end
  end

endmodule

/* hdl/periodic_waveform_generator.sv */
// Channel  Direction  Handshake           Payload
// in       input      in_valid, in_stall  restart
// out      output     out_valid, out_stall sample, point_index, clipped
// cfg      input      cfg_write           cfg_index, cfg_data
//
// One timebase tick item is taken per clock while in_stall is low; a tick that
// completes a point enters a five-register pipeline that ends in the output register.
// The stage count is set by the amplitude multiply and the reciprocal multiply
// that divides triangle and sawtooth terms by the point count.
// Synchronous reset clears the counters and valid flags and loads default settings.
// in_stall rises only when every pipeline register holds an item and out is stalled.
module periodic_waveform_generator import pwg_pkg::*; #(
  parameter int POINTS = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] sample,
  output logic [6:0]  point_index,
  output logic        clipped,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(POINTS);

  cfg_t        cfg;
  logic [31:0] ticks_per_point;

  logic                req_valid;
  logic                req_ready;
  logic [IW-1:0]       req_index;
  logic [ROM_AW-1:0]   req_rom_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_shape  <= SHAPE_SINE;
      cfg.amplitude   <= '0;
      cfg.mean_offset <= '0;
      ticks_per_point <= 32'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WAVE_SHAPE:      cfg.wave_shape  <= shape_t'(cfg_data[1:0]);
        REG_AMPLITUDE:       cfg.amplitude   <= cfg_data[15:0];
        REG_MEAN_OFFSET:     cfg.mean_offset <= signed'(cfg_data[15:0]);
        REG_TICKS_PER_POINT: ticks_per_point <= cfg_data;
      endcase
    end
  end

  assign in_stall = !req_ready;

  pwg_sequencer #(
    .POINTS(POINTS)
  ) u_sequencer (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .restart         (restart),
    .ticks_per_point (ticks_per_point),
    .req_ready       (req_ready),
    .req_valid       (req_valid),
    .req_index       (req_index),
    .req_rom_addr    (req_rom_addr)
  );

  pwg_shaper #(
    .POINTS(POINTS)
  ) u_shaper (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req_valid    (req_valid),
    .req_index    (req_index),
    .req_rom_addr (req_rom_addr),
    .req_ready    (req_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .point_index  (point_index),
    .clipped      (clipped)
  );

endmodule

/* hdl/pwg_checker.sv */
`include "assert_macros.svh"

module pwg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] sample,
  input logic [6:0]  point_index,
  input logic        clipped
);

  `PWG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `PWG_ASSERT(a_out_stable, out_valid && out_stall |=> $stable({sample, point_index, clipped}))
  `PWG_ASSERT(a_clip_rail, out_valid && clipped |-> sample == 16'h0000 || sample == 16'hFFFF)
  `PWG_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind periodic_waveform_generator pwg_checker u_pwg_checker (.*);

/* tb/tb_periodic_waveform_generator.sv */
`timescale 1ns / 1ps

import pwg_pkg::*;

typedef struct packed {
  bit [15:0] code;
  bit [6:0]  index;
  bit        clip;
} wave_point_t;

class waveform_scoreboard;
  int          points;
  shape_t      shape;
  bit [15:0]   amp;
  bit [15:0]   mean;
  bit [31:0]   period;
  int          point_cnt;
  bit [31:0]   tick_cnt;
  shortint     sine_table [100];
  wave_point_t expected_points [$];
  int          errors;
  int          ticks;
  int          checked;
  int          clipped_seen;

  function new(input int n_points);
    int unsigned quarter [26] = '{
      0, 2057, 4107, 6140, 8149, 10126, 12062, 13952, 15786, 17557,
      19260, 20886, 22431, 23886, 25247, 26509, 27666, 28714, 29648, 30466,
      31163, 31738, 32187, 32509, 32702, 32767};
    points = n_points;
    shape = SHAPE_SINE;
    amp = '0;
    mean = '0;
    period = 32'd1;
    point_cnt = 0;
    tick_cnt = '0;
    errors = 0;
    ticks = 0;
    checked = 0;
    clipped_seen = 0;
    for (int k = 0; k < 100; k++) begin
      if (k <= 25) sine_table[k] = shortint'(quarter[k]);
      else if (k <= 50) sine_table[k] = shortint'(quarter[50 - k]);
      else if (k <= 75) sine_table[k] = -shortint'(quarter[k - 50]);
      else sine_table[k] = -shortint'(quarter[100 - k]);
    end
  endfunction

  function void write_reg(input logic [1:0] idx, input bit [31:0] data);
    case (idx)
      REG_WAVE_SHAPE:      shape = shape_t'(data[1:0]);
      REG_AMPLITUDE:       amp = data[15:0];
      REG_MEAN_OFFSET:     mean = data[15:0];
      REG_TICKS_PER_POINT: period = data;
      default: ;
    endcase
  endfunction

  function wave_point_t wave_point(input int i);
    longint      centre;
    longint      a;
    longint      ii;
    longint      p;
    longint      den;
    longint      term;
    longint      total;
    longint      q;
    wave_point_t pt;
    centre = 32768 + longint'($signed(mean));
    a = longint'(amp);
    ii = i;
    p = points;
    case (shape)
      SHAPE_SINE: begin
        den = 131072;
        term = a * longint'(sine_table[(ii * 100) / p]);
      end
      SHAPE_SQUARE: begin
        den = 131072;
        term = (2 * ii < p) ? a * 32768 : -a * 32768;
      end
      SHAPE_TRIANGLE: begin
        den = p;
        if (ii <= p / 2) term = (p / 4 - ii) * a;
        else term = (p / 4 - p / 2 + (ii - p / 2)) * a;
      end
      default: begin
        den = 2 * p;
        term = (ii - p / 2) * a;
      end
    endcase
    total = centre * den + term;
    pt.index = i[6:0];
    if (total < 0) begin
      pt.code = 16'd0;
      pt.clip = 1'b1;
    end else begin
      q = total / den;
      pt.clip = (q > 65535);
      pt.code = (q > 65535) ? 16'hFFFF : q[15:0];
    end
    return pt;
  endfunction

  function void note_tick(input bit restart);
    longint unsigned limit;
    longint unsigned count;
    int              idx;
    ticks++;
    limit = (period == 0) ? 1 : longint'(period);
    if (restart) begin
      point_cnt = 0;
      tick_cnt = '0;
    end
    count = longint'(tick_cnt) + 1;
    if (count < limit) begin
      tick_cnt = count[31:0];
      return;
    end
    tick_cnt = '0;
    idx = (point_cnt < points) ? point_cnt : 0;
    expected_points.push_back(wave_point(idx));
    point_cnt = (idx + 1 >= points) ? 0 : idx + 1;
  endfunction

  task report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_point(input bit [15:0] code, input bit [6:0] index, input bit clip);
    wave_point_t want;
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("unexpected point, sample %0d index %0d", code, index));
      return;
    end
    want = expected_points.pop_front();
    checked++;
    if (clip) clipped_seen++;
    if (code !== want.code)
      report_mismatch($sformatf("point %0d: sample %0d, expected %0d",
                                want.index, code, want.code));
    if (index !== want.index)
      report_mismatch($sformatf("point_index %0d, expected %0d", index, want.index));
    if (clip !== want.clip)
      report_mismatch($sformatf("point %0d: clipped %0b, expected %0b",
                                want.index, clip, want.clip));
  endtask
endclass

module tb_periodic_waveform_generator;
  localparam int POINTS = 100;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] sample;
  logic [6:0]  point_index;
  logic        clipped;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_output = 1'b0;
  int cycle_count = 0;
  int input_stalls = 0;
  int settings_used = 0;

  waveform_scoreboard sb;

  periodic_waveform_generator #(.POINTS(POINTS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart(restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample(sample),
    .point_index(point_index),
    .clipped(clipped),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_point(sample, point_index, clipped);
    end
  end

  initial begin : receiver
    int wait_cycles;
    forever begin
      wait_cycles = rx_burst ? 0 : $urandom_range(0, 16);
      if (hold_output) begin
        hold_output = 1'b0;
        wait_cycles = wait_cycles + LONG_HOLD;
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_tick(input bit r);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= r;
    @(posedge clk);
    while (in_stall) begin
      input_stalls++;
      @(posedge clk);
    end
    sb.note_tick(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input shape_t s, input bit [15:0] a, input bit [15:0] m,
                             input bit [31:0] p);
    logic [1:0] regs [4];
    bit [31:0]  vals [4];
    regs = '{REG_WAVE_SHAPE, REG_AMPLITUDE, REG_MEAN_OFFSET, REG_TICKS_PER_POINT};
    vals[0] = $urandom();
    vals[0][1:0] = s;
    vals[1] = $urandom();
    vals[1][15:0] = a;
    vals[2] = $urandom();
    vals[2][15:0] = m;
    vals[3] = p;
    for (int k = 0; k < 4; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      @(posedge clk);
      sb.write_reg(regs[k], vals[k]);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int        n;
    int        phase;
    int        random_ticks;
    shape_t    s;
    bit [15:0] a;
    bit [15:0] m;
    bit [31:0] p;
    sb = new(POINTS);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tick(1'b0);
    send_tick(1'b0);

    drain();
    load_config(SHAPE_SQUARE, 16'hFFFF, 16'h0000, 32'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    drain();
    load_config(SHAPE_TRIANGLE, 16'hFFFF, 16'h7FFF, 32'd1);
    send_tick(1'b0);
    send_tick(1'b0);

    drain();
    load_config(SHAPE_SAWTOOTH, 16'hFFFF, 16'h8000, 32'd1);
    send_tick(1'b0);
    send_tick(1'b0);

    // A long period followed by a short one: the count already exceeds it.
    drain();
    load_config(SHAPE_SINE, 16'hFFFF, 16'd16384, 32'hFFFF_FFFF);
    repeat (4) send_tick(1'b0);
    drain();
    load_config(SHAPE_SINE, 16'hFFFF, 16'd16384, 32'd2);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    phase = 0;
    random_ticks = 0;
    while (random_ticks < 400) begin
      drain();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      s = shape_t'($urandom_range(0, 3));
      case ($urandom_range(0, 6))
        0: a = 16'h0000;
        1: a = 16'hFFFF;
        default: a = $urandom_range(0, 65535);
      endcase
      if ($urandom_range(0, 4) == 0) m = $urandom_range(0, 65535);
      else m = 16'($urandom_range(0, 32768) - 16384);
      case ($urandom_range(0, 9))
        0: p = 32'd0;
        7, 8: p = $urandom_range(2, 4);
        9: p = 32'd7;
        default: p = 32'd1;
      endcase
      n = $urandom_range(20, 50);
      // Stall the output for a long stretch while ticks keep coming.
      if (phase == 2) begin
        p = 32'd1;
        tx_burst = 1'b1;
        hold_output = 1'b1;
        n = 40;
      end
      load_config(s, a, m, p);
      repeat (n) send_tick($urandom_range(0, 31) == 0);
      random_ticks += n;
      phase++;
    end

    drain();
    $display("Sent %0d ticks across %0d register settings; %0d input stall cycles seen.",
             sb.ticks, settings_used, input_stalls);
    $display("Checked %0d points, %0d of them clipped, with %0d mismatches.",
             sb.checked, sb.clipped_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
